[hw/rtl/mmr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmr_pkg
// Shared types, codes and field widths for the rectangular matrix multiplier.
// ----------------------------------------------------------------------------
package mmr_pkg;

  // Field widths of the input item, the result item and the register port
  localparam int CMD_W     = 2;
  localparam int IDX_W_IN  = 5;
  localparam int ELEM_W    = 16;
  localparam int PROD_W    = 2 * ELEM_W;
  localparam int SUM_W     = 48;
  localparam int CFG_W     = 6;
  localparam int CFG_IDX_W = 1;
  // Holds an effective dimension up to the largest supported size (32)
  localparam int DIM_W     = CFG_W + 1;

  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(32);

  // Commands
  localparam logic [CMD_W-1:0] CMD_WR_A    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WR_B    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_COMPUTE = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROWS_M  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_N = 1'd1;

  typedef logic signed [ELEM_W-1:0] elem_t;
  typedef logic signed [SUM_W-1:0]  sum_t;

  // Write strobes toward the element stores
  typedef struct packed {
    logic a_we;
    logic b_we;
  } store_we_t;

  // Control toward the multiply-accumulate pipeline
  typedef struct packed {
    logic issue;
    logic clear;
  } mac_ctl_t;

endpackage

[hw/rtl/mmr_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmr_in_if / mmr_out_if
// Valid/ready channels for load/compute items and for result elements.
// ----------------------------------------------------------------------------
interface mmr_in_if import mmr_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    cmd;
  logic [IDX_W_IN-1:0] row_index;
  logic [IDX_W_IN-1:0] col_index;
  elem_t               element_value;

  modport source (output valid, cmd, row_index, col_index, element_value,
                  input ready);
  modport sink   (input valid, cmd, row_index, col_index, element_value,
                  output ready);
endinterface

interface mmr_out_if import mmr_pkg::*; ();
  logic                valid;
  logic                ready;
  sum_t                product_value;
  logic [IDX_W_IN-1:0] result_column;
  logic                last_in_row;

  modport source (output valid, product_value, result_column, last_in_row,
                  input ready);
  modport sink   (input valid, product_value, result_column, last_in_row,
                  output ready);
endinterface

[hw/rtl/mmr_store.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmr_store
// Element stores for A and B: one write port and one synchronous read port
// each, read data registered.
// ----------------------------------------------------------------------------
module mmr_store import mmr_pkg::*; #(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10
) (
  input  logic              clk,
  input  store_we_t         we,
  input  logic [ADDR_W-1:0] wr_addr,
  input  elem_t             wr_data,
  input  logic [ADDR_W-1:0] a_rd_addr,
  input  logic [ADDR_W-1:0] b_rd_addr,
  output elem_t             a_rd_data,
  output elem_t             b_rd_data
);

  elem_t mem_a [DEPTH];
  elem_t mem_b [DEPTH];
  elem_t a_rd_r;
  elem_t b_rd_r;

  always_ff @(posedge clk) begin
    if (we.a_we) begin
      mem_a[wr_addr] <= wr_data;
    end
    a_rd_r <= mem_a[a_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (we.b_we) begin
      mem_b[wr_addr] <= wr_data;
    end
    b_rd_r <= mem_b[b_rd_addr];
  end

  assign a_rd_data = a_rd_r;
  assign b_rd_data = b_rd_r;

endmodule

[hw/rtl/mmr_mac.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmr_mac
// Multiply-accumulate pipeline: store read, registered product, 48-bit sum.
// ----------------------------------------------------------------------------
module mmr_mac import mmr_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  mac_ctl_t ctl,
  input  elem_t    a_data,
  input  elem_t    b_data,
  output logic     busy,
  output sum_t     acc
);

  logic                     rd_vld_r;
  logic                     mul_vld_r;
  logic signed [PROD_W-1:0] prod_r;
  sum_t                     acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r  <= 1'b0;
      mul_vld_r <= 1'b0;
    end else begin
      rd_vld_r  <= ctl.issue;
      mul_vld_r <= rd_vld_r;
    end
  end

  // Store data is valid in the cycle after issue
  always_ff @(posedge clk) begin
    prod_r <= a_data * b_data;
  end

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      acc_r <= '0;
    end else if (mul_vld_r) begin
      acc_r <= acc_r + SUM_W'(prod_r);
    end
  end

  assign busy = rd_vld_r | mul_vld_r;
  assign acc  = acc_r;

endmodule

[hw/rtl/matrix_multiply_rect.sv]
`timescale 1ns / 1ps
// Compute: a row issues n products for each column, then drains the
//   read/multiply/accumulate pipeline before the column's sum is output;
//   when n is zero each column outputs a zero sum without issuing.
// Throughput: one multiply-accumulate per cycle while a column issues;
//   one item in flight at a time.
// Reset: synchronous, active low; registers return to 32, stores keep contents.
// ----------------------------------------------------------------------------
// matrix_multiply_rect
// C = A * B with A m-by-n and B n-by-m, signed Q8.8 elements and exact 48-bit
// sums. Load items write single elements; a compute item streams one row of C.
// ----------------------------------------------------------------------------
module matrix_multiply_rect import mmr_pkg::*; #(
  parameter int MAX_DIM = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  mmr_in_if.sink               in_ch,
  mmr_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int IDX_W  = $clog2(MAX_DIM);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ISSUE = 2'd1;
  localparam logic [1:0] ST_WAIT  = 2'd2;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [CFG_W-1:0] rows_m_r;
  logic [CFG_W-1:0] inner_n_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_m_r  <= CFG_RESET;
      inner_n_r <= CFG_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROWS_M:  rows_m_r  <= cfg_wdata;
        REG_INNER_N: inner_n_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Clamp oversized dimensions to the store size
  logic [DIM_W-1:0] m_eff;
  logic [DIM_W-1:0] n_eff;

  assign m_eff = (DIM_W'(rows_m_r) > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM)
                                                       : DIM_W'(rows_m_r);
  assign n_eff = (DIM_W'(inner_n_r) > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM)
                                                        : DIM_W'(inner_n_r);

  // --------------------------------------------------------------------------
  // Input decode
  // --------------------------------------------------------------------------
  logic [1:0]       state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             in_xfer;
  logic [DIM_W-1:0] in_row;
  logic [DIM_W-1:0] in_col;
  logic             wr_a_ok;
  logic             wr_b_ok;
  logic             start_ok;
  store_we_t        store_we;
  logic [ADDR_W-1:0] wr_addr;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign in_row      = DIM_W'(in_ch.row_index);
  assign in_col      = DIM_W'(in_ch.col_index);

  // Drop loads with indices, and computes with a row, outside the current dimensions
  assign wr_a_ok  = (in_ch.cmd == CMD_WR_A) && (in_row < m_eff) && (in_col < n_eff);
  assign wr_b_ok  = (in_ch.cmd == CMD_WR_B) && (in_row < n_eff) && (in_col < m_eff);
  assign start_ok = (in_ch.cmd == CMD_COMPUTE) && (in_row < m_eff);

  assign store_we.a_we = in_xfer && wr_a_ok;
  assign store_we.b_we = in_xfer && wr_b_ok;
  assign wr_addr = ADDR_W'(in_ch.row_index) * ADDR_W'(MAX_DIM)
                 + ADDR_W'(in_ch.col_index);

  // --------------------------------------------------------------------------
  // Row sequencer: walk k for each column j, then hand the sum to the output
  // --------------------------------------------------------------------------
  logic [IDX_W-1:0] row_r, row_nxt;
  logic [IDX_W-1:0] j_r, j_nxt;
  logic [IDX_W-1:0] k_r, k_nxt;
  mac_ctl_t         mac_ctl;
  logic             mac_busy;
  sum_t             mac_acc;
  logic             out_load;
  logic             col_last;
  logic [1:0]       col_entry;

  assign col_last  = (DIM_W'(j_r) == m_eff - DIM_W'(1));
  // With an empty dot product go straight to the drain state and emit zero
  assign col_entry = (n_eff == '0) ? ST_WAIT : ST_ISSUE;
  assign out_load  = (state_r == ST_WAIT) && !mac_busy
                   && (!out_valid_r || out_ch.ready);

  always_comb begin
    state_nxt     = state_r;
    row_nxt       = row_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    mac_ctl.issue = 1'b0;
    mac_ctl.clear = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer && start_ok) begin
          row_nxt       = IDX_W'(in_ch.row_index);
          j_nxt         = '0;
          k_nxt         = '0;
          mac_ctl.clear = 1'b1;
          state_nxt     = col_entry;
        end
      end
      ST_ISSUE: begin
        mac_ctl.issue = 1'b1;
        k_nxt         = k_r + IDX_W'(1);
        if (DIM_W'(k_r) == n_eff - DIM_W'(1)) begin
          state_nxt = ST_WAIT;
        end
      end
      ST_WAIT: begin
        // Hold until the pipeline drains and the output register frees up
        if (out_load) begin
          if (col_last) begin
            state_nxt = ST_IDLE;
          end else begin
            j_nxt         = j_r + IDX_W'(1);
            k_nxt         = '0;
            mac_ctl.clear = 1'b1;
            state_nxt     = col_entry;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    row_r <= row_nxt;
    j_r   <= j_nxt;
    k_r   <= k_nxt;
  end

  // --------------------------------------------------------------------------
  // Element stores and multiply-accumulate
  // --------------------------------------------------------------------------
  logic [ADDR_W-1:0] a_rd_addr;
  logic [ADDR_W-1:0] b_rd_addr;
  elem_t             a_rd_data;
  elem_t             b_rd_data;

  assign a_rd_addr = ADDR_W'(row_r) * ADDR_W'(MAX_DIM) + ADDR_W'(k_r);
  assign b_rd_addr = ADDR_W'(k_r) * ADDR_W'(MAX_DIM) + ADDR_W'(j_r);

  mmr_store #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk       (clk),
    .we        (store_we),
    .wr_addr   (wr_addr),
    .wr_data   (in_ch.element_value),
    .a_rd_addr (a_rd_addr),
    .b_rd_addr (b_rd_addr),
    .a_rd_data (a_rd_data),
    .b_rd_data (b_rd_data)
  );

  mmr_mac u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (mac_ctl),
    .a_data (a_rd_data),
    .b_data (b_rd_data),
    .busy   (mac_busy),
    .acc    (mac_acc)
  );

  // --------------------------------------------------------------------------
  // Output register: one result held until its transfer
  // --------------------------------------------------------------------------
  sum_t                out_value_r;
  logic [IDX_W_IN-1:0] out_col_r;
  logic                out_last_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_value_r <= mac_acc;
      out_col_r   <= IDX_W_IN'(j_r);
      out_last_r  <= col_last;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.product_value = out_value_r;
  assign out_ch.result_column = out_col_r;
  assign out_ch.last_in_row   = out_last_r;

endmodule

[hw/rtl/mmr_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmr_checker
// Port-level checks on the matrix multiplier, bound to the top level.
// ----------------------------------------------------------------------------
module mmr_checker import mmr_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic [CMD_W-1:0]    in_cmd,
  input logic                out_valid,
  input logic                out_ready,
  input sum_t                out_value,
  input logic [IDX_W_IN-1:0] out_col,
  input logic                out_last
);

  // A stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value)
      && $stable(out_col) && $stable(out_last))
    else $error("result changed while stalled");

  // Input closes only after a compute transfer
  a_ready_fall: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $fell(in_ready) |-> $past(in_valid && in_cmd == CMD_COMPUTE))
    else $error("input closed without a compute transfer");

  // Input reopens together with the final result of the row
  a_ready_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $rose(in_ready) |-> out_valid && out_last)
    else $error("input reopened before the row finished");

  // While a non-final result is pending the row is still in progress
  a_busy_mid_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready)
    else $error("input open in the middle of a row");

endmodule

bind matrix_multiply_rect mmr_checker u_mmr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_cmd    (in_ch.cmd),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_value (out_ch.product_value),
  .out_col   (out_ch.result_column),
  .out_last  (out_ch.last_in_row)
);

[sim/tb_matrix_multiply_rect.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_matrix_multiply_rect
// Self-checking bench for the rectangular matrix multiplier. A driver feeds
// load and compute items from a queue. A shadow copy of both element stores
// works out every row of C as items transfer. A monitor checks each result
// element in order. The run walks through a series of matrix shapes and
// handshake stall patterns.
// ----------------------------------------------------------------------------
module tb_matrix_multiply_rect;
  import mmr_pkg::*;

  localparam int MAX_DIM = 32;
  // cmd 3 decodes to nothing; the block must drop it
  localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;

  // Cycles with no transfer on either channel before the run is declared hung.
  // The longest quiet stretch is the forced receiver hold plus one column of
  // a 32-term dot product, so this leaves plenty of margin.
  localparam int QUIET_LIMIT    = 3000;
  localparam int HOLD_CYCLES    = 400;
  localparam int HOLD_AT_RESULT = 20;
  // Covers a trailing load or a dropped item still in the block
  localparam int DRAIN_CYCLES   = 8;
  localparam int MAX_PRINTED    = 40;

  typedef struct {
    logic [CMD_W-1:0]    cmd;
    logic [IDX_W_IN-1:0] row;
    logic [IDX_W_IN-1:0] col;
    elem_t               value;
  } host_item_t;

  typedef struct {
    sum_t                value;
    logic [IDX_W_IN-1:0] column;
    logic                last;
  } c_element_t;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_ROWS_M;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  mmr_in_if  in_ch ();
  mmr_out_if out_ch ();

  matrix_multiply_rect DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #2 clk = ~clk;

  // Items waiting for the driver, and C elements waiting for the monitor
  host_item_t host_items[$];
  c_element_t awaited_c[$];

  // Stimulus side: which store entries the host has written so far, and the
  // shape that the items being generated are meant for
  bit          a_loaded [MAX_DIM][MAX_DIM];
  bit          b_loaded [MAX_DIM][MAX_DIM];
  int unsigned gen_m = MAX_DIM;
  int unsigned gen_n = MAX_DIM;

  // Prediction side: shadow stores and shadow registers
  elem_t            a_shadow [MAX_DIM][MAX_DIM];
  elem_t            b_shadow [MAX_DIM][MAX_DIM];
  logic [CFG_W-1:0] shadow_rows  = CFG_RESET;
  logic [CFG_W-1:0] shadow_inner = CFG_RESET;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned mismatches    = 0;
  int unsigned results_seen  = 0;
  int unsigned hold_left     = 0;
  bit          hold_done     = 1'b0;
  int unsigned quiet_cycles  = 0;

  task automatic report_mismatch(string what);
    if (mismatches < MAX_PRINTED) $display("[%0t] mismatch: %s", $time, what);
    mismatches++;
  endtask

  // Register values above MAX_DIM act as MAX_DIM
  function automatic int unsigned effective_dim(logic [CFG_W-1:0] r);
    return (r > MAX_DIM) ? MAX_DIM : r;
  endfunction

  // Queue one item. Before a compute, load any entry that the row would read
  // and that the host has never written, so no unwritten entry is ever read.
  task automatic queue_item(logic [CMD_W-1:0] cmd, int unsigned row, int unsigned col,
                            logic [ELEM_W-1:0] value);
    host_item_t item;
    if (cmd == CMD_COMPUTE && row < gen_m) begin
      for (int k = 0; k < gen_n; k++) begin
        if (!a_loaded[row][k]) queue_item(CMD_WR_A, row, k, ELEM_W'($urandom));
        for (int j = 0; j < gen_m; j++)
          if (!b_loaded[k][j]) queue_item(CMD_WR_B, k, j, ELEM_W'($urandom));
      end
    end
    if (cmd == CMD_WR_A && row < gen_m && col < gen_n) a_loaded[row][col] = 1'b1;
    if (cmd == CMD_WR_B && row < gen_n && col < gen_m) b_loaded[row][col] = 1'b1;
    item.cmd   = cmd;
    item.row   = IDX_W_IN'(row);
    item.col   = IDX_W_IN'(col);
    item.value = value;
    host_items = {host_items, item};
  endtask

  // Mostly in-range loads and computes with random content; the rest is
  // noise: any command, including the unused one, with any indexes.
  task automatic random_items(int count);
    int unsigned      pick;
    int unsigned      row;
    int unsigned      col;
    logic [CMD_W-1:0] cmd;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      cmd  = CMD_W'($urandom_range(0, 3));
      row  = $urandom_range(0, MAX_DIM - 1);
      col  = $urandom_range(0, MAX_DIM - 1);
      if (pick < 50 && gen_m > 0 && gen_n > 0) begin
        if ($urandom_range(0, 1) == 0) begin
          cmd = CMD_WR_A;
          row = $urandom_range(0, gen_m - 1);
          col = $urandom_range(0, gen_n - 1);
        end else begin
          cmd = CMD_WR_B;
          row = $urandom_range(0, gen_n - 1);
          col = $urandom_range(0, gen_m - 1);
        end
      end else if (pick < 80 && gen_m > 0) begin
        cmd = CMD_COMPUTE;
        row = $urandom_range(0, gen_m - 1);
      end
      queue_item(cmd, row, col, ELEM_W'($urandom));
    end
  endtask

  // Predict the effect of one transferred item on the shadow stores, and
  // queue the row of C that a compute produces.
  task automatic apply_host_item(logic [CMD_W-1:0] cmd, logic [IDX_W_IN-1:0] row,
                                 logic [IDX_W_IN-1:0] col, elem_t value);
    int unsigned m;
    int unsigned n;
    sum_t        acc;
    c_element_t  elem;
    m = effective_dim(shadow_rows);
    n = effective_dim(shadow_inner);
    if (cmd == CMD_WR_A) begin
      if (row < m && col < n) a_shadow[row][col] = value;
    end else if (cmd == CMD_WR_B) begin
      if (row < n && col < m) b_shadow[row][col] = value;
    end else if (cmd == CMD_COMPUTE && row < m) begin
      for (int j = 0; j < m; j++) begin
        acc = '0;
        for (int k = 0; k < n; k++)
          acc += sum_t'(a_shadow[row][k]) * sum_t'(b_shadow[k][j]);
        elem.value  = acc;
        elem.column = IDX_W_IN'(j);
        elem.last   = (j == m - 1);
        awaited_c = {awaited_c, elem};
      end
    end
  endtask

  // Hold until every queued item has transferred and every C element is back.
  // Sample away from the rising edge so the driver's updates have settled.
  task automatic wait_idle();
    while (host_items.size() != 0 || in_ch.valid || awaited_c.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] index, logic [CFG_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Drain the block, then switch shape and stall pattern
  task automatic apply_setting(logic [CFG_W-1:0] rows, logic [CFG_W-1:0] inner,
                               int unsigned send_pct, int unsigned recv_pct);
    wait_idle();
    write_register(REG_ROWS_M, rows);
    write_register(REG_INNER_N, inner);
    gen_m = effective_dim(rows);
    gen_n = effective_dim(inner);
    send_idle_pct <= send_pct;
    recv_idle_pct <= recv_pct;
  endtask

  // Driver: advance to the next queued item whenever the current one has
  // transferred or none is on offer; idle at random between items.
  always @(posedge clk) begin : host_driver
    host_item_t next_item;
    if (!rst_n) begin
      in_ch.valid  <= 1'b0;
      shadow_rows  <= CFG_RESET;
      shadow_inner <= CFG_RESET;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_ROWS_M) shadow_rows <= cfg_wdata;
        else if (cfg_index == REG_INNER_N) shadow_inner <= cfg_wdata;
      end
      if (in_ch.valid && in_ch.ready)
        apply_host_item(in_ch.cmd, in_ch.row_index, in_ch.col_index, in_ch.element_value);
      if (!in_ch.valid || in_ch.ready) begin
        if (host_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          next_item = host_items.pop_front();
          in_ch.cmd           <= next_item.cmd;
          in_ch.row_index     <= next_item.row;
          in_ch.col_index     <= next_item.col;
          in_ch.element_value <= next_item.value;
          in_ch.valid         <= 1'b1;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each C element against the oldest prediction. Once, well
  // into the run, drop ready for a long stretch so the block backs up and
  // stalls its input while the driver keeps offering items.
  always @(posedge clk) begin : c_monitor
    c_element_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (awaited_c.size() == 0) begin
          report_mismatch($sformatf("unexpected C element, column %0d",
                                    out_ch.result_column));
        end else begin
          want = awaited_c.pop_front();
          if (out_ch.product_value !== want.value)
            report_mismatch($sformatf("column %0d value %0d, want %0d",
                                      want.column, out_ch.product_value, want.value));
          if (out_ch.result_column !== want.column)
            report_mismatch($sformatf("column %0d, want %0d",
                                      out_ch.result_column, want.column));
          if (out_ch.last_in_row !== want.last)
            report_mismatch($sformatf("column %0d last flag %b, want %b",
                                      want.column, out_ch.last_in_row, want.last));
        end
        results_seen++;
        if (!hold_done && results_seen == HOLD_AT_RESULT) begin
          hold_left = HOLD_CYCLES;
          hold_done = 1'b1;
        end
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog: end the run if neither channel moves for too long
  always @(posedge clk) begin : watchdog
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    // Drive every input to a known value from time zero
    in_ch.valid         = 1'b0;
    in_ch.cmd           = CMD_WR_A;
    in_ch.row_index     = '0;
    in_ch.col_index     = '0;
    in_ch.element_value = '0;
    out_ch.ready        = 1'b0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part on a 2x3 by 3x2 shape: full-scale positive and negative
    // elements, then loads outside the shape, the unused command and computes
    // of rows past the end, none of which may disturb the stored matrices.
    apply_setting(6'd2, 6'd3, 6, 61);
    queue_item(CMD_WR_A, 0, 0, 16'h8000);
    queue_item(CMD_WR_A, 0, 1, 16'h7FFF);
    queue_item(CMD_WR_A, 0, 2, 16'hFFFF);
    queue_item(CMD_WR_A, 1, 0, 16'h8000);
    queue_item(CMD_WR_A, 1, 1, 16'h0001);
    queue_item(CMD_WR_A, 1, 2, 16'h7FFF);
    queue_item(CMD_WR_B, 0, 0, 16'h8000);
    queue_item(CMD_WR_B, 0, 1, 16'h7FFF);
    queue_item(CMD_WR_B, 1, 0, 16'h8000);
    queue_item(CMD_WR_B, 1, 1, 16'hFFFF);
    queue_item(CMD_WR_B, 2, 0, 16'h7FFF);
    queue_item(CMD_WR_B, 2, 1, 16'h0100);
    queue_item(CMD_COMPUTE, 0, 0, 16'h0000);
    queue_item(CMD_COMPUTE, 1, 31, 16'hFFFF);
    queue_item(CMD_WR_A, 2, 0, 16'h0000);
    queue_item(CMD_WR_A, 0, 3, 16'h5555);
    queue_item(CMD_WR_B, 3, 0, 16'hAAAA);
    queue_item(CMD_WR_B, 0, 2, 16'h0000);
    queue_item(CMD_WR_A, 31, 31, 16'h1234);
    queue_item(CMD_WR_B, 31, 31, 16'hEDCB);
    queue_item(CMD_NONE, 0, 0, 16'h4321);
    queue_item(CMD_COMPUTE, 2, 0, 16'h0000);
    queue_item(CMD_COMPUTE, 31, 31, 16'h0000);
    queue_item(CMD_COMPUTE, 0, 0, 16'h0000);
    queue_item(CMD_COMPUTE, 1, 0, 16'h0000);

    // Random part. Sender idles lightly and receiver heavily first, then the
    // other way round, then neither. Shapes cover single elements, the full
    // width on either side, a zero row count that drops everything, a zero
    // dot length that yields zero sums, and oversized register values.
    apply_setting(6'd1, 6'd1, 6, 61);
    random_items(10);
    apply_setting(6'd5, 6'd7, 6, 61);
    random_items(20);
    apply_setting(6'd32, 6'd1, 6, 61);
    random_items(10);
    apply_setting(6'd1, 6'd32, 61, 6);
    random_items(10);
    apply_setting(6'd0, 6'd9, 61, 6);
    random_items(8);
    apply_setting(6'd4, 6'd0, 61, 6);
    random_items(8);
    apply_setting(6'd63, 6'd1, 61, 6);
    random_items(8);
    apply_setting(6'd1, 6'd63, 0, 0);
    random_items(8);
    apply_setting(6'd6, 6'd6, 0, 0);
    random_items(12);
    apply_setting(6'd3, 6'd5, 0, 0);
    random_items(10);

    wait_idle();
    repeat (4 * DRAIN_CYCLES) @(posedge clk);
    if (awaited_c.size() != 0)
      report_mismatch($sformatf("%0d C elements never arrived", awaited_c.size()));
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[matrix_multiply_rect.f]
hw/rtl/mmr_pkg.sv
hw/rtl/mmr_if.sv
hw/rtl/mmr_store.sv
hw/rtl/mmr_mac.sv
hw/rtl/matrix_multiply_rect.sv
hw/rtl/mmr_checker.sv
sim/tb_matrix_multiply_rect.sv
